>>> rtl/core/dsb_pkg.sv
// Shared types and codes for the delay-and-sum FIR beamformer.
package dsb_pkg;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic              op;
    logic              channel;
    logic [6:0]        tap_index;
    logic signed [15:0] coef_value;
    logic signed [15:0] mic_a_sample;
    logic signed [15:0] mic_b_sample;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] beam_sample;
    logic              saturated;
  } beam_t;

endpackage

>>> rtl/core/delay_and_sum_fir_beamformer.sv
// Two-channel delay-and-sum beamformer: one shared MAC over tap and history RAMs.
// Load item: writes one tap weight if its tap index is below TAPS, gives no result.
// Sample item: the result comes from the single MAC that walks TAPS taps of each channel,
//   one RAM read per cycle.
// A new item is taken only once the previous sample item has reached the output register.
// Reset: synchronous; then a clearing pass zeroes both RAMs, no item taken.
module delay_and_sum_fir_beamformer #(
  parameter int TAPS = 65
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  dsb_pkg::cmd_t cmd,
  output logic          beam_valid,
  input  logic          beam_stall,
  output dsb_pkg::beam_t beam
);

  import dsb_pkg::*;

  localparam int WW    = $clog2(TAPS);
  localparam int HW    = (TAPS > 2) ? $clog2(TAPS - 1) : 1;
  localparam int ACC_W = 32 + WW + 1;

  localparam logic [WW-1:0] K_LAST  = WW'(TAPS - 1);
  localparam logic [HW-1:0] HD_LAST = HW'(TAPS - 2);
  localparam logic [7:0]    TAPS_L  = 8'(TAPS);

  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(-32768);
  localparam logic signed [ACC_W-1:0] BIAS  = ACC_W'(65535);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]    state;
  logic          clr_ch;
  logic [WW-1:0] clr_tap;
  logic          ch;
  logic [WW-1:0] k;
  logic [HW-1:0] rd;
  logic [HW-1:0] wr_ptr;
  logic signed [15:0] sa;
  logic signed [15:0] sb;

  logic          v1, v1_k0, v1_ch;
  logic          v2;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;

  logic [15:0]   w_q, h_q;
  logic signed [15:0] x;

  logic          w_we;
  logic [WW:0]   w_waddr;
  logic [15:0]   w_wdata;
  logic          h_we;
  logic [HW:0]   h_waddr;
  logic [15:0]   h_wdata;

  logic          take;
  logic          issue;
  logic          out_free;
  logic signed [ACC_W-1:0] rounded;
  logic signed [ACC_W-1:0] y;
  beam_t         result;

  function automatic logic [HW-1:0] prev_idx(input logic [HW-1:0] i);
    prev_idx = (i == '0) ? HD_LAST : i - 1'b1;
  endfunction

  assign cmd_stall = (state != S_IDLE);
  assign take      = cmd_valid && !cmd_stall;
  assign issue     = (state == S_ISSUE);
  assign out_free  = !beam_valid || !beam_stall;

  // Weight RAM write: clearing pass or load item.
  always_comb begin
    w_we    = 1'b0;
    w_waddr = {clr_ch, clr_tap};
    w_wdata = '0;
    if (state == S_CLEAR) begin
      w_we = 1'b1;
    end else if (take && cmd.op == OP_LOAD && {1'b0, cmd.tap_index} < TAPS_L) begin
      w_we    = 1'b1;
      w_waddr = {cmd.channel, cmd.tap_index[WW-1:0]};
      w_wdata = cmd.coef_value;
    end
  end

  // History RAM write: clearing pass, then the fresh sample of each channel once its
  // oldest entry has been read.
  always_comb begin
    h_we    = 1'b0;
    h_waddr = {clr_ch, clr_tap[HW-1:0]};
    h_wdata = '0;
    if (state == S_CLEAR) begin
      h_we = (clr_tap < K_LAST);
    end else if (issue && ch && k == '0) begin
      h_we    = 1'b1;
      h_waddr = {1'b0, wr_ptr};
      h_wdata = sa;
    end else if (state == S_DRAIN && v1) begin
      h_we    = 1'b1;
      h_waddr = {1'b1, wr_ptr};
      h_wdata = sb;
    end
  end

  dsb_ram #(.WIDTH(16), .DEPTH(2 ** (WW + 1))) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr ({ch, k}),
    .rdata (w_q)
  );

  dsb_ram #(.WIDTH(16), .DEPTH(2 ** (HW + 1))) u_history (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr ({ch, rd}),
    .rdata (h_q)
  );

  // Tap zero takes the new sample, not the delay line.
  assign x = v1_k0 ? (v1_ch ? sb : sa) : $signed(h_q);

  // Divide by 2^16 toward zero, then clip.
  always_comb begin
    rounded = acc + (acc[ACC_W-1] ? BIAS : '0);
    y       = rounded >>> 16;
    result.saturated   = 1'b0;
    result.beam_sample = y[15:0];
    if (y > Y_MAX) begin
      result.beam_sample = 16'sh7fff;
      result.saturated   = 1'b1;
    end else if (y < Y_MIN) begin
      result.beam_sample = -16'sh8000;
      result.saturated   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_ch     <= 1'b0;
      clr_tap    <= '0;
      ch         <= 1'b0;
      k          <= '0;
      rd         <= '0;
      wr_ptr     <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      beam_valid <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (beam_valid && !beam_stall && state != S_FIN) begin
        beam_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_tap == K_LAST) begin
            clr_tap <= '0;
            clr_ch  <= 1'b1;
            if (clr_ch) begin
              state <= S_IDLE;
            end
          end else begin
            clr_tap <= clr_tap + 1'b1;
          end
        end
        S_IDLE: begin
          if (take && cmd.op == OP_SAMPLE) begin
            state <= S_ISSUE;
            ch    <= 1'b0;
            k     <= '0;
            rd    <= prev_idx(wr_ptr);
          end
        end
        S_ISSUE: begin
          if (k == K_LAST) begin
            k  <= '0;
            rd <= prev_idx(wr_ptr);
            if (ch) begin
              state <= S_DRAIN;
            end else begin
              ch <= 1'b1;
            end
          end else begin
            k <= k + 1'b1;
            if (k != '0) begin
              rd <= prev_idx(rd);
            end
          end
        end
        S_DRAIN: begin
          if (v1) begin
            wr_ptr <= (wr_ptr == HD_LAST) ? '0 : wr_ptr + 1'b1;
          end
          if (!v1 && !v2) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register can take the item
          if (out_free) begin
            beam_valid <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    v1_k0 <= (k == '0);
    v1_ch <= ch;
    prod  <= $signed(w_q) * x;
    if (take && cmd.op == OP_SAMPLE) begin
      sa  <= cmd.mic_a_sample;
      sb  <= cmd.mic_b_sample;
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (state == S_FIN && out_free) begin
      beam <= result;
    end
  end

  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(beam_valid) |-> $past(state) == S_FIN)
    else $error("result shown without a finished sum");

  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    take && cmd.op == OP_SAMPLE |=> state == S_ISSUE && ch == 1'b0 && k == '0)
    else $error("sample item did not start at channel zero, tap zero");

  a_wr_ptr_range: assert property (@(posedge clk) disable iff (rst)
    wr_ptr <= HD_LAST)
    else $error("history write pointer out of range");

  a_k_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> k <= K_LAST)
    else $error("tap counter beyond last tap");

  a_no_mac_outside: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN) |-> !v1 && !v2)
    else $error("MAC pipeline busy while no sample is in work");

endmodule

>>> rtl/core/dsb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module dsb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/beam_checker.sv
// Checker for the beamformer: tracks taps and history, predicts and compares each beam item.
module beam_checker #(
  parameter int TAPS = 65
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  logic           cmd_stall,
  input  dsb_pkg::cmd_t  cmd,
  input  logic           beam_valid,
  input  logic           beam_stall,
  input  dsb_pkg::beam_t beam,
  output int             fail_count,
  output int             pending
);
  import dsb_pkg::*;

  localparam int CHANNELS = 2;

  logic signed [15:0] weights [CHANNELS][TAPS];
  logic signed [15:0] history [CHANNELS][TAPS-1];
  beam_t              expected_beams [$];
  int                 errors = 0;

  // Exact FIR sum for one channel, then shift the new sample into its delay line.
  function automatic longint filter_channel(input int ch, input logic signed [15:0] fresh);
    longint acc;
    acc = longint'(weights[ch][0]) * longint'(fresh);
    for (int k = 1; k < TAPS; k++) begin
      acc += longint'(weights[ch][k]) * longint'(history[ch][k-1]);
    end
    for (int k = TAPS - 2; k > 0; k--) begin
      history[ch][k] = history[ch][k-1];
    end
    history[ch][0] = fresh;
    return acc;
  endfunction

  function automatic beam_t form_beam(input logic signed [15:0] a, input logic signed [15:0] b);
    longint total;
    longint scaled;
    beam_t  res;
    total = filter_channel(0, a) + filter_channel(1, b);
    // Signed division truncates toward zero.
    scaled = total / 64'sd65536;
    res.saturated = 1'b0;
    if (scaled > 32767) begin
      scaled = 32767;
      res.saturated = 1'b1;
    end else if (scaled < -32768) begin
      scaled = -32768;
      res.saturated = 1'b1;
    end
    res.beam_sample = scaled[15:0];
    return res;
  endfunction

  always @(posedge clk) begin
    beam_t want;
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        for (int k = 0; k < TAPS; k++) weights[c][k] = '0;
        for (int k = 0; k < TAPS - 1; k++) history[c][k] = '0;
      end
      expected_beams.delete();
    end else begin
      // Retire the output item first: it always belongs to an older sample item.
      if (beam_valid && !beam_stall) begin
        if (expected_beams.size() == 0) begin
          $display("%0t: unexpected item, expected none, got beam_sample %0d saturated %0b",
                   $time, beam.beam_sample, beam.saturated);
          errors++;
        end else begin
          want = expected_beams.pop_front();
          if (beam.beam_sample !== want.beam_sample) begin
            $display("%0t: beam_sample mismatch, expected %0d, got %0d",
                     $time, want.beam_sample, beam.beam_sample);
            errors++;
          end
          if (beam.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %0b, got %0b",
                     $time, want.saturated, beam.saturated);
            errors++;
          end
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (cmd.op == OP_LOAD) begin
          // Drop loads past the last tap.
          if (cmd.tap_index < TAPS) weights[cmd.channel][cmd.tap_index] = cmd.coef_value;
        end else begin
          expected_beams.push_back(form_beam(cmd.mic_a_sample, cmd.mic_b_sample));
        end
      end
    end
    fail_count <= errors;
    pending <= expected_beams.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the beamformer testbench: clock, reset, stimulus, receiver stalls and verdict.
module testbench;
  import dsb_pkg::*;

  localparam int TAPS         = 65;
  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 1500000;

  logic  clk;
  logic  rst;
  logic  cmd_valid;
  logic  cmd_stall;
  cmd_t  cmd;
  logic  beam_valid;
  logic  beam_stall;
  beam_t beam;
  int    fail_count;
  int    pending;
  int    idle_pct = 0;
  int    stall_pct = 0;
  int    sent_count = 0;
  int    cycle_count = 0;

  delay_and_sum_fir_beamformer #(
    .TAPS(TAPS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .beam_valid (beam_valid),
    .beam_stall (beam_stall),
    .beam       (beam)
  );

  beam_checker #(
    .TAPS(TAPS)
  ) beam_check (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd        (cmd),
    .beam_valid (beam_valid),
    .beam_stall (beam_stall),
    .beam       (beam),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off so the block backs up into its input.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    beam_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held && sent_count >= 300) begin
        held = 1'b1;
        hold_left = 700;
      end
      if (hold_left > 0) begin
        beam_stall <= 1'b1;
        hold_left--;
      end else begin
        beam_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  function automatic cmd_t scrambled();
    logic [63:0] bits;
    cmd_t item;
    bits = {$urandom, $urandom};
    item = bits[$bits(cmd_t)-1:0];
    return item;
  endfunction

  function automatic logic signed [15:0] tap_weight();
    logic signed [15:0] w;
    w = 16'($urandom);
    return w >>> $urandom_range(0, 7);
  endfunction

  function automatic logic signed [15:0] audio_value();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 3))
      0: return v;
      1: return v >>> 8;
      2: return v[15] ? 16'sh8000 : 16'sh7fff;
      default: return v >>> 3;
    endcase
  endfunction

  task automatic send_item(input cmd_t item);
    while ($urandom_range(0, 99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd <= item;
    do @(posedge clk); while (cmd_stall);
    sent_count++;
  endtask

  task automatic load_tap(input logic ch, input int tap, input logic signed [15:0] w);
    cmd_t item;
    item = scrambled();
    item.op = OP_LOAD;
    item.channel = ch;
    item.tap_index = tap[6:0];
    item.coef_value = w;
    send_item(item);
  endtask

  task automatic play_pair(input logic signed [15:0] a, input logic signed [15:0] b);
    cmd_t item;
    item = scrambled();
    item.op = OP_SAMPLE;
    item.mic_a_sample = a;
    item.mic_b_sample = b;
    send_item(item);
  endtask

  initial begin
    int counted;
    int tap_pos;
    logic ch;
    rst <= 1'b1;
    cmd_valid <= 1'b0;
    cmd <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Full-scale taps and samples drive the sum past both rails.
    load_tap(1'b0, 0, -16'sd32768);
    load_tap(1'b0, 1, -16'sd32768);
    load_tap(1'b1, 0, -16'sd32768);
    load_tap(1'b1, 1, -16'sd32768);
    // Out-of-range taps must leave the filters alone.
    load_tap(1'b0, TAPS, 16'sd32767);
    load_tap(1'b1, 127, -16'sd32768);
    play_pair(-16'sd32768, -16'sd32768);
    play_pair(-16'sd32768, -16'sd32768);
    play_pair(16'sd32767, 16'sd32767);
    play_pair(16'sd32767, 16'sd32767);
    // Negative non-integer quotient checks truncation toward zero.
    play_pair(-16'sd32768, 16'sd32767);
    load_tap(1'b0, TAPS - 1, 16'sd32767);
    load_tap(1'b1, TAPS - 1, -16'sd1);
    load_tap(1'b0, 0, 16'sd0);
    load_tap(1'b1, 1, 16'sd0);
    load_tap(1'b0, 1, 16'sd1);
    play_pair(16'sd0, 16'sd0);
    play_pair(16'sd32767, -16'sd32768);
    play_pair(-16'sd1, 16'sd1);
    play_pair(16'sd100, -16'sd100);

    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      case (counted * 4 / RANDOM_ITEMS)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct = 37;
          stall_pct = 37;
        end
      endcase
      if ($urandom_range(0, 99) < 15) begin
        // Retune one channel: a run of adjacent taps, now and then a stray index past the end.
        ch = 1'($urandom_range(0, 1));
        tap_pos = $urandom_range(0, TAPS - 1);
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 11) == 0) begin
            load_tap(ch, $urandom_range(TAPS, 127), tap_weight());
          end else begin
            load_tap(ch, tap_pos, tap_weight());
            tap_pos = (tap_pos + 1) % TAPS;
            counted++;
          end
        end
      end else begin
        repeat ($urandom_range(1, 10)) begin
          play_pair(audio_value(), audio_value());
          counted++;
        end
      end
    end
    cmd_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
